// ===== rtl/gbbs_pkg.sv =====
// package for the grid binned box search block
// holds opcodes, status codes and shared types; no dependencies
package gbbs_pkg;

    localparam int GRID_COLS_DEF  = 64;
    localparam int GRID_ROWS_DEF  = 48;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_HITS_DEF   = 64;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_MATCH    = 3'd0;
    localparam logic [2:0] ST_NO_MATCH = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_OFF_GRID = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MIN_Y = 2'd1;
    localparam logic [1:0] REG_CWI   = 2'd2;
    localparam logic [1:0] REG_CHI   = 2'd3;

    // rounding mode for the shared multiplier result
    typedef enum logic [1:0] {
        RND_ROUND = 2'd0,
        RND_FLOOR = 2'd1,
        RND_CEIL  = 2'd2
    } rnd_mode_t;

    // command to the shared multiply/round unit
    typedef struct packed {
        logic             start;
        logic signed [17:0] diff;
        logic [15:0]      inv;
        rnd_mode_t        mode;
    } mul_req_t;

    // answer of the multiply/round unit
    typedef struct packed {
        logic             done;
        logic signed [18:0] cell_num;
    } mul_rsp_t;

endpackage

// ===== rtl/grid_binned_box_search_top.sv =====
// top level of the grid binned box search block: sequencer, stores and ports
// depends on gbbs_pkg and gbbs_mul_unit
//
// Each transaction is handled alone; s_tready is high only while the block is
// idle. After reset a clearing pass over all GRID_COLS*GRID_ROWS cells (3072
// with the default grid) zeroes the cell occupancy memory before the first
// transaction is taken, and a clear op runs the same one-cell-a-cycle sweep
// before its result. An insert makes two passes through the shared two-stage
// multiplier, then, for a cell on the grid, the cell read and write; a full
// table answers without the multiplier. A query works out the four window
// bounds through the same multiplier and the range check, then scans each
// cell of the window and walks its chain one keypoint at a time, with an
// extra step per match, as each memory has a single read port; each result
// waits for m_tready.
module grid_binned_box_search_top #(
    parameter int GRID_COLS  = gbbs_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = gbbs_pkg::GRID_ROWS_DEF,
    parameter int MAX_POINTS = gbbs_pkg::MAX_POINTS_DEF,
    parameter int MAX_HITS   = gbbs_pkg::MAX_HITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [17:2] pos_x, [33:18] pos_y, [48:34] radius, zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [12:3] kp_index, zero fill
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // [0] truncated
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gbbs_pkg::*;

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int PW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int XW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int YW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int HW     = $clog2(MAX_HITS + 1);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR, S_CLR_OUT,
        S_I_MX, S_I_MXW, S_I_MY, S_I_MYW, S_I_RD, S_I_WR, S_I_OUT,
        S_Q_M0, S_Q_W0, S_Q_M1, S_Q_W1, S_Q_M2, S_Q_W2, S_Q_M3, S_Q_W3,
        S_Q_CHK, S_Q_CELL, S_Q_CELLW, S_Q_PT, S_Q_PTW, S_Q_TEST, S_Q_EMIT,
        S_Q_NEXT, S_OUT
    } state_t;

    // configuration
    logic signed [15:0] min_x_reg, min_y_reg;
    logic [15:0]        cwi_reg, chi_reg;
    logic               cfg_wr;

    // memories
    logic [15:0] px_mem [MAX_POINTS];
    logic [15:0] py_mem [MAX_POINTS];
    logic [PW-1:0] nxt_mem [MAX_POINTS];
    logic [PW-1:0] head_mem [NCELLS];
    logic [PW-1:0] tail_mem [NCELLS];
    logic          occ_mem [NCELLS];

    state_t             state_reg;
    logic [NW-1:0]      count_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [14:0]        r_reg;
    logic signed [18:0] cx_reg, x0_reg, x1_reg, y0_reg, y1_reg;
    logic [XW-1:0]      ix_reg;
    logic [YW-1:0]      iy_reg;
    logic [CW-1:0]      caddr_reg;
    logic [PW-1:0]      j_reg;
    logic [NW-1:0]      steps_reg;
    logic [HW-1:0]      n_reg;
    logic               occ_rd_reg;
    logic [PW-1:0]      head_rd_reg, tail_rd_reg, nxt_rd_reg;
    logic [15:0]        px_rd_reg, py_rd_reg;
    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic [9:0]         m_idx_reg;
    logic               m_last_reg, m_trunc_reg;
    logic [2:0]         res_status_reg;
    logic [9:0]         res_idx_reg;
    logic               res_trunc_reg;
    logic               pend_reg;
    logic [PW-1:0]      pend_idx_reg;
    mul_req_t           mreq;
    mul_rsp_t           mrsp;

    gbbs_mul_unit u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    // apb config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            cwi_reg   <= 16'd410;
            chi_reg   <= 16'd410;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_MIN_X: min_x_reg <= pwdata[15:0];
                REG_MIN_Y: min_y_reg <= pwdata[15:0];
                REG_CWI:   cwi_reg   <= pwdata[15:0];
                REG_CHI:   chi_reg   <= pwdata[15:0];
                default:   ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[3:2])
            REG_MIN_X: prdata = {{16{min_x_reg[15]}}, min_x_reg};
            REG_MIN_Y: prdata = {{16{min_y_reg[15]}}, min_y_reg};
            REG_CWI:   prdata = {16'd0, cwi_reg};
            REG_CHI:   prdata = {16'd0, chi_reg};
            default:   prdata = '0;
        endcase
    end

    // multiplier operand selection
    logic signed [17:0] dxq, dyq;
    assign dxq = 18'(x_reg) - 18'(min_x_reg);
    assign dyq = 18'(y_reg) - 18'(min_y_reg);
    always_comb begin
        mreq.start = 1'b0;
        mreq.diff  = dxq;
        mreq.inv   = cwi_reg;
        mreq.mode  = RND_ROUND;
        unique case (state_reg)
            S_I_MX: mreq.start = 1'b1;
            S_I_MY: begin
                mreq.start = 1'b1; mreq.diff = dyq; mreq.inv = chi_reg;
            end
            S_Q_M0: begin
                mreq.start = 1'b1; mreq.diff = dxq - 18'(r_reg); mreq.mode = RND_FLOOR;
            end
            S_Q_M1: begin
                mreq.start = 1'b1; mreq.diff = dxq + 18'(r_reg); mreq.mode = RND_CEIL;
            end
            S_Q_M2: begin
                mreq.start = 1'b1; mreq.diff = dyq - 18'(r_reg);
                mreq.inv = chi_reg; mreq.mode = RND_FLOOR;
            end
            S_Q_M3: begin
                mreq.start = 1'b1; mreq.diff = dyq + 18'(r_reg);
                mreq.inv = chi_reg; mreq.mode = RND_CEIL;
            end
            default: ;
        endcase
    end

    // window hit test of the fetched point
    logic signed [16:0] ddx, ddy;
    logic [16:0]        adx, ady;
    logic               hit;
    assign ddx = 17'($signed(px_rd_reg)) - 17'(x_reg);
    assign ddy = 17'($signed(py_rd_reg)) - 17'(y_reg);
    assign adx = ddx[16] ? 17'(-ddx) : 17'(ddx);
    assign ady = ddy[16] ? 17'(-ddy) : 17'(ddy);
    assign hit = (adx < 17'(r_reg)) && (ady < 17'(r_reg));

    // output register load: only when it is free
    logic out_free;
    logic out_load;
    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && ((state_reg == S_CLR_OUT) || (state_reg == S_OUT) ||
                                   (state_reg == S_Q_EMIT && pend_reg));
    assign s_tready = (state_reg == S_IDLE);

    // memory ports: clocked reads and writes
    logic          occ_we, occ_wd, hd_we, tl_we, nx_we, pt_we;
    logic [CW-1:0] occ_wa;
    logic [PW-1:0] nx_wa;
    always_comb begin
        occ_we = 1'b0; occ_wd = 1'b0; occ_wa = caddr_reg;
        hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pt_we = 1'b0;
        nx_wa = tail_rd_reg;
        unique case (state_reg)
            S_INIT, S_CLR: occ_we = 1'b1;
            S_I_MX: pt_we = 1'b1;
            S_I_WR: begin
                occ_we = 1'b1; occ_wd = 1'b1; tl_we = 1'b1;
                hd_we = !occ_rd_reg; nx_we = occ_rd_reg;
            end
            default: ;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (occ_we) occ_mem[occ_wa] <= occ_wd;
        if (hd_we) head_mem[caddr_reg] <= count_reg[PW-1:0];
        if (tl_we) tail_mem[caddr_reg] <= count_reg[PW-1:0];
        if (nx_we) nxt_mem[nx_wa] <= count_reg[PW-1:0];
        if (pt_we) begin
            px_mem[count_reg[PW-1:0]] <= x_reg;
            py_mem[count_reg[PW-1:0]] <= y_reg;
        end
        occ_rd_reg  <= occ_mem[caddr_reg];
        head_rd_reg <= head_mem[caddr_reg];
        tail_rd_reg <= tail_mem[caddr_reg];
        nxt_rd_reg  <= nxt_mem[j_reg];
        px_rd_reg   <= px_mem[j_reg];
        py_rd_reg   <= py_mem[j_reg];
    end

    logic [CW-1:0] cell_of_xy;
    assign cell_of_xy = CW'(ix_reg * GRID_ROWS + iy_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            count_reg   <= '0;
            caddr_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= out_load | (m_valid_reg & ~m_tready);
            unique case (state_reg)
                S_INIT, S_CLR: begin
                    caddr_reg <= caddr_reg + 1'b1;
                    if (caddr_reg == CW'(NCELLS - 1))
                        state_reg <= (state_reg == S_INIT) ? S_IDLE : S_CLR_OUT;
                end
                S_CLR_OUT: if (out_free) begin
                    count_reg <= '0;
                    m_status_reg <= ST_CLEARED;
                    m_idx_reg <= '0; m_last_reg <= 1'b1; m_trunc_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_IDLE: if (s_tvalid) begin
                    x_reg  <= s_tdata[17:2];
                    y_reg  <= s_tdata[33:18];
                    r_reg  <= s_tdata[48:34];
                    caddr_reg <= '0;
                    unique case (s_tdata[1:0])
                        OP_CLEAR:  state_reg <= S_CLR;
                        OP_INSERT: state_reg <= (count_reg >= NW'(MAX_POINTS)) ? S_OUT : S_I_MX;
                        OP_QUERY:  state_reg <= S_Q_M0;
                        default:   state_reg <= S_IDLE;
                    endcase
                    res_status_reg <= ST_FULL; res_idx_reg <= '0;
                    res_trunc_reg <= 1'b0;
                end
                S_I_MX: state_reg <= S_I_MXW;
                S_I_MXW: if (mrsp.done) begin
                    cx_reg <= mrsp.cell_num; state_reg <= S_I_MY;
                end
                S_I_MY: state_reg <= S_I_MYW;
                S_I_MYW: if (mrsp.done) begin
                    res_idx_reg <= 10'(count_reg);
                    if (cx_reg < 0 || cx_reg >= 19'(GRID_COLS) ||
                        mrsp.cell_num < 0 || mrsp.cell_num >= 19'(GRID_ROWS)) begin
                        res_status_reg <= ST_OFF_GRID;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        caddr_reg <= CW'(cx_reg[XW-1:0] * GRID_ROWS + mrsp.cell_num[YW-1:0]);
                        state_reg <= S_I_RD;
                    end
                end
                S_I_RD: state_reg <= S_I_WR;
                S_I_WR: begin
                    count_reg <= count_reg + 1'b1;
                    res_status_reg <= ST_INSERTED;
                    state_reg <= S_OUT;
                end
                S_Q_M0: state_reg <= S_Q_W0;
                S_Q_W0: if (mrsp.done) begin x0_reg <= mrsp.cell_num; state_reg <= S_Q_M1; end
                S_Q_M1: state_reg <= S_Q_W1;
                S_Q_W1: if (mrsp.done) begin x1_reg <= mrsp.cell_num; state_reg <= S_Q_M2; end
                S_Q_M2: state_reg <= S_Q_W2;
                S_Q_W2: if (mrsp.done) begin y0_reg <= mrsp.cell_num; state_reg <= S_Q_M3; end
                S_Q_M3: state_reg <= S_Q_W3;
                S_Q_W3: if (mrsp.done) begin y1_reg <= mrsp.cell_num; state_reg <= S_Q_CHK; end
                S_Q_CHK: begin
                    n_reg <= '0;
                    res_status_reg <= ST_NO_MATCH;
                    if (x0_reg >= 19'(GRID_COLS) || x1_reg < 0 ||
                        y0_reg >= 19'(GRID_ROWS) || y1_reg < 0 || x0_reg > x1_reg ||
                        y0_reg > y1_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        ix_reg <= (x0_reg < 0) ? '0 : x0_reg[XW-1:0];
                        iy_reg <= (y0_reg < 0) ? '0 : y0_reg[YW-1:0];
                        if (x1_reg > 19'(GRID_COLS - 1)) x1_reg <= 19'(GRID_COLS - 1);
                        if (y1_reg > 19'(GRID_ROWS - 1)) y1_reg <= 19'(GRID_ROWS - 1);
                        if (y0_reg < 0) y0_reg <= '0;
                        state_reg <= S_Q_CELL;
                    end
                end
                S_Q_CELL: begin caddr_reg <= cell_of_xy; state_reg <= S_Q_CELLW; end
                S_Q_CELLW: state_reg <= S_Q_PT;
                S_Q_PT: begin
                    if (!occ_rd_reg) state_reg <= S_Q_NEXT;
                    else begin
                        j_reg <= head_rd_reg; steps_reg <= '0; state_reg <= S_Q_PTW;
                    end
                end
                S_Q_PTW: state_reg <= S_Q_TEST;
                S_Q_TEST: begin
                    if (hit) begin
                        if (n_reg >= HW'(MAX_HITS)) begin
                            res_trunc_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_Q_EMIT;
                        end
                    end else if (j_reg == tail_rd_reg || steps_reg >= NW'(MAX_POINTS - 1)) begin
                        state_reg <= S_Q_NEXT;
                    end else begin
                        j_reg <= nxt_rd_reg; steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_Q_PTW;
                    end
                end
                S_Q_EMIT: if (out_free || !pend_reg) begin
                    // previous hit is released, this one held until the next is known
                    if (pend_reg) begin
                        m_status_reg <= ST_MATCH;
                        m_idx_reg <= 10'(pend_idx_reg); m_last_reg <= 1'b0;
                        m_trunc_reg <= 1'b0;
                    end
                    pend_reg <= 1'b1; pend_idx_reg <= j_reg;
                    n_reg <= n_reg + 1'b1;
                    if (j_reg == tail_rd_reg || steps_reg >= NW'(MAX_POINTS - 1)) begin
                        state_reg <= S_Q_NEXT;
                    end else begin
                        j_reg <= nxt_rd_reg; steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_Q_PTW;
                    end
                end
                S_Q_NEXT: begin
                    if (19'(iy_reg) < y1_reg) begin
                        iy_reg <= iy_reg + 1'b1; state_reg <= S_Q_CELL;
                    end else if (19'(ix_reg) < x1_reg) begin
                        ix_reg <= ix_reg + 1'b1; iy_reg <= y0_reg[YW-1:0];
                        state_reg <= S_Q_CELL;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (out_free) begin
                    m_last_reg  <= 1'b1;
                    m_trunc_reg <= res_trunc_reg;
                    if (pend_reg) begin
                        m_status_reg <= ST_MATCH;
                        m_idx_reg <= 10'(pend_idx_reg);
                        pend_reg <= 1'b0;
                    end else begin
                        m_status_reg <= res_status_reg;
                        m_idx_reg <= res_idx_reg;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_idx_reg, m_status_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_trunc_reg;
endmodule

// ===== rtl/gbbs_mul_unit.sv =====
// shared multiply and round unit: q.16 cell number from difference times inverse
// depends on gbbs_pkg
module gbbs_mul_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  gbbs_pkg::mul_req_t req,
    output gbbs_pkg::mul_rsp_t rsp
);
    import gbbs_pkg::*;

    logic signed [34:0] prod_reg;
    logic               prod_vld_reg;
    rnd_mode_t          mode_reg;
    logic signed [18:0] cell_reg;
    logic               done_reg;
    logic [34:0]        mag;
    logic [34:0]        adj;
    logic [18:0]        q;
    logic               neg;

    // stage 1: multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= req.start;
        end
        prod_reg <= req.diff * $signed({1'b0, req.inv});
        mode_reg <= req.mode;
    end

    // stage 2: round magnitude, restore sign
    always_comb begin
        neg = prod_reg[34];
        mag = neg ? 35'(-prod_reg) : 35'(prod_reg);
        adj = mag;
        unique case (mode_reg)
            RND_ROUND: adj = mag + 35'h8000;
            RND_FLOOR: adj = neg ? mag + 35'hFFFF : mag;
            RND_CEIL:  adj = neg ? mag : mag + 35'hFFFF;
            default:   adj = mag;
        endcase
        q = adj[34:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= prod_vld_reg;
        end
        cell_reg <= neg ? -$signed(q) : $signed(q);
    end

    assign rsp.done     = done_reg;
    assign rsp.cell_num = cell_reg;
endmodule

// ===== tb/sv/gbbs_checker.sv =====
// checker for the grid binned box search block: watches the stream and config ports
// predicts every result transaction and compares; depends on gbbs_pkg
`timescale 1ns / 100ps

module gbbs_checker
    import gbbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    localparam int NCOLS = GRID_COLS_DEF;
    localparam int NROWS = GRID_ROWS_DEF;
    localparam int NPTS  = MAX_POINTS_DEF;
    localparam int NHITS = MAX_HITS_DEF;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] kp_index;
        logic       last;
        logic       truncated;
    } search_result_t;

    search_result_t expected_results[$];

    // shadow copy of the block state
    logic signed [15:0] grid_min_x, grid_min_y;
    logic [15:0]        inv_w, inv_h;
    logic signed [15:0] pt_x[NPTS];
    logic signed [15:0] pt_y[NPTS];
    int                 chain_next[NPTS];
    int                 head_of[NCOLS*NROWS];
    int                 tail_of[NCOLS*NROWS];
    bit                 occupied[NCOLS*NROWS];
    int                 n_points;

    function automatic longint cell_round(longint p);
        if (p >= 0) return (p + 64'h8000) >>> 16;
        return -((-p + 64'h8000) >>> 16);
    endfunction

    function automatic longint cell_floor(longint p);
        if (p >= 0) return p >>> 16;
        return -((-p + 64'hFFFF) >>> 16);
    endfunction

    function automatic longint cell_ceil(longint p);
        if (p >= 0) return (p + 64'hFFFF) >>> 16;
        return -((-p) >>> 16);
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic search_result_t mk(logic [2:0] st, int idx, bit lst, bit tr);
        search_result_t r;
        r.status    = st;
        r.kp_index  = idx[9:0];
        r.last      = lst;
        r.truncated = tr;
        return r;
    endfunction

    // append one expected result at the tail
    function automatic void add_expect(search_result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    // work out the results of one accepted input transaction
    task automatic predict_search(input logic [55:0] d);
        logic [1:0]         op;
        logic signed [15:0] x, y;
        longint             r, cx, cy, x0, x1, y0, y1, ix, iy;
        int                 idx, c, j, steps, n;
        bit                 trunc, stop;
        search_result_t     hits[$];
        op = d[1:0];
        x  = d[17:2];
        y  = d[33:18];
        r  = longint'(d[48:34]);
        case (op)
            OP_CLEAR: begin
                foreach (occupied[k]) occupied[k] = 0;
                n_points = 0;
                add_expect(mk(ST_CLEARED, 0, 1, 0));
            end
            OP_INSERT: begin
                if (n_points >= NPTS) begin
                    add_expect(mk(ST_FULL, 0, 1, 0));
                end else begin
                    idx = n_points;
                    pt_x[idx] = x;
                    pt_y[idx] = y;
                    n_points++;
                    cx = cell_round((longint'(x) - grid_min_x) * longint'(inv_w));
                    cy = cell_round((longint'(y) - grid_min_y) * longint'(inv_h));
                    if (cx < 0 || cx >= NCOLS || cy < 0 || cy >= NROWS) begin
                        add_expect(mk(ST_OFF_GRID, idx, 1, 0));
                    end else begin
                        c = int'(cx) * NROWS + int'(cy);
                        if (!occupied[c]) begin
                            head_of[c]  = idx;
                            occupied[c] = 1;
                        end else begin
                            chain_next[tail_of[c]] = idx;
                        end
                        tail_of[c] = idx;
                        add_expect(mk(ST_INSERTED, idx, 1, 0));
                    end
                end
            end
            OP_QUERY: begin
                x0 = cell_floor((longint'(x) - grid_min_x - r) * longint'(inv_w));
                x1 = cell_ceil((longint'(x) - grid_min_x + r) * longint'(inv_w));
                y0 = cell_floor((longint'(y) - grid_min_y - r) * longint'(inv_h));
                y1 = cell_ceil((longint'(y) - grid_min_y + r) * longint'(inv_h));
                if (x0 < 0) x0 = 0;
                if (x1 > NCOLS - 1) x1 = NCOLS - 1;
                if (y0 < 0) y0 = 0;
                if (y1 > NROWS - 1) y1 = NROWS - 1;
                n = 0;
                trunc = 0;
                if (!(x0 >= NCOLS || x1 < 0 || y0 >= NROWS || y1 < 0)) begin
                    // column-major walk, each chain in insertion order
                    for (ix = x0; ix <= x1 && !trunc; ix++) begin
                        for (iy = y0; iy <= y1 && !trunc; iy++) begin
                            c = int'(ix) * NROWS + int'(iy);
                            if (!occupied[c]) continue;
                            j = head_of[c];
                            steps = 0;
                            stop = 0;
                            while (!stop && steps < NPTS) begin
                                if (abs_l(longint'(pt_x[j]) - x) < r &&
                                    abs_l(longint'(pt_y[j]) - y) < r) begin
                                    if (n >= NHITS) begin
                                        trunc = 1;
                                        stop = 1;
                                    end else begin
                                        hits.insert(hits.size(), mk(ST_MATCH, j, 0, 0));
                                        n++;
                                    end
                                end
                                if (!stop) begin
                                    if (j == tail_of[c]) stop = 1;
                                    else begin
                                        j = chain_next[j];
                                        steps++;
                                    end
                                end
                            end
                        end
                    end
                end
                if (n == 0) begin
                    add_expect(mk(ST_NO_MATCH, 0, 1, 0));
                end else begin
                    hits[n-1].last      = 1;
                    hits[n-1].truncated = trunc;
                    foreach (hits[k]) add_expect(hits[k]);
                end
            end
            default: ;  // unused code: nothing happens
        endcase
    endtask

    always @(posedge aclk) begin
        search_result_t e;
        if (!aresetn) begin
            grid_min_x <= '0;
            grid_min_y <= '0;
            inv_w      <= 16'd410;
            inv_h      <= 16'd410;
            n_points   = 0;
            foreach (occupied[k]) occupied[k] = 0;
            expected_results.delete();
            fail_count   <= 0;
            result_count <= 0;
            pending      <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_MIN_X: grid_min_x <= pwdata[15:0];
                    REG_MIN_Y: grid_min_y <= pwdata[15:0];
                    REG_CWI:   inv_w      <= pwdata[15:0];
                    REG_CHI:   inv_h      <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_search(s_tdata);
            // result transaction compare
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction status=%0d", m_tdata[2:0]);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[2:0] !== e.status || m_tdata[12:3] !== e.kp_index ||
                        m_tlast !== e.last || m_tuser !== e.truncated) begin
                        fail_count <= fail_count + 1;
                        if (m_tdata[2:0] !== e.status)
                            $error("status expected %0d actual %0d", e.status, m_tdata[2:0]);
                        if (m_tdata[12:3] !== e.kp_index)
                            $error("kp_index expected %0d actual %0d", e.kp_index,
                                   m_tdata[12:3]);
                        if (m_tlast !== e.last)
                            $error("last expected %0d actual %0d", e.last, m_tlast);
                        if (m_tuser !== e.truncated)
                            $error("truncated expected %0d actual %0d", e.truncated, m_tuser);
                    end
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_grid_binned_box_search_top.sv =====
// testbench top for the grid binned box search block: clock, reset, stimulus, verdict
// depends on gbbs_pkg, grid_binned_box_search_top and gbbs_checker
`timescale 1ns / 100ps

module tb_grid_binned_box_search_top;
    import gbbs_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, result_count;
    bit          calm = 0;      // no idling in the last part
    bit          hold_long = 0; // receiver long hold-off request
    int          item_count = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    grid_binned_box_search_top dut (.*);

    gbbs_checker u_checker (.*);

    // receiver: random stall bursts and one long hold-off
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_long) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge aclk);
            end
        end
    end

    // setup and access cycle; the caller returns the bus to idle
    task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= {16'h0, val};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
    endtask

    // tvalid stays up after acceptance until a gap or a drain drops it
    task automatic send_item(input logic [1:0] op, input logic [15:0] px,
                             input logic [15:0] py, input logic [14:0] rad);
        int g;
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 0;
            g = $urandom_range(1, 14);
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'b0, rad, py, px, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        item_count++;
    endtask

    // wait for the block to drain before a register write
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (3200) @(posedge aclk);
    endtask

    // keypoint near a centre, in Q12.4 pixels
    task automatic send_near(input logic [1:0] op, input int cx, input int cy,
                             input int spread, input int rad);
        send_item(op, 16'(cx + $urandom_range(0, 2*spread) - spread),
                  16'(cy + $urandom_range(0, 2*spread) - spread), 15'(rad));
    endtask

    initial begin
        int k, sel;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: inserts, off-grid, extremes, queries, zero radius, unused op
        send_item(OP_INSERT, 16'd800, 16'd800, 15'd0);
        send_item(OP_INSERT, 16'd810, 16'd790, 15'h7FFF);
        send_item(OP_INSERT, 16'h8000, 16'h8000, 15'd0);
        send_item(OP_INSERT, 16'h7FFF, 16'h7FFF, 15'd0);
        send_item(OP_INSERT, 16'hFFFF, 16'd0, 15'd0);
        send_item(OP_QUERY, 16'd800, 16'd800, 15'd64);
        send_item(OP_QUERY, 16'd800, 16'd800, 15'd0);
        send_item(OP_QUERY, 16'h8000, 16'h8000, 15'd16);
        send_item(OP_QUERY, 16'h7FFF, 16'h7FFF, 15'd100);
        send_item(OP_QUERY, 16'd0, 16'd0, 15'h7FFF);
        send_item(2'd3, 16'hAAAA, 16'h5555, 15'h2AAA);
        // crowd one spot to force truncation
        for (k = 0; k < 70; k++) send_near(OP_INSERT, 1600, 1600, 8, 0);
        hold_long = 1;   // receiver holds off while queries pile up
        send_item(OP_QUERY, 16'd1600, 16'd1600, 15'd40);
        send_item(OP_QUERY, 16'd1600, 16'd1600, 15'd3);
        send_item(OP_CLEAR, 16'h5555, 16'hAAAA, 15'h5555);
        send_item(OP_QUERY, 16'd1600, 16'd1600, 15'd40);
        drain();

        // register settings, extremes included
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin reg_write(REG_MIN_X, 16'h8000); reg_write(REG_MIN_Y, 16'h7FFF);
                         reg_write(REG_CWI, 16'hFFFF); reg_write(REG_CHI, 16'h0000); end
                1: begin reg_write(REG_MIN_X, 16'hFF00); reg_write(REG_MIN_Y, 16'h0100);
                         reg_write(REG_CWI, 16'd820); reg_write(REG_CHI, 16'd205); end
                2: begin reg_write(REG_MIN_X, 16'($urandom)); reg_write(REG_MIN_Y, 16'($urandom));
                         reg_write(REG_CWI, 16'($urandom_range(1, 4000)));
                         reg_write(REG_CHI, 16'($urandom_range(1, 4000))); end
                3: begin reg_write(REG_MIN_X, 16'h7FFF); reg_write(REG_MIN_Y, 16'h8000);
                         reg_write(REG_CWI, 16'd1); reg_write(REG_CHI, 16'hFFFF); end
                default: begin reg_write(REG_MIN_X, 16'd0); reg_write(REG_MIN_Y, 16'd0);
                         reg_write(REG_CWI, 16'd410); reg_write(REG_CHI, 16'd410); end
            endcase
            psel <= 0; penable <= 0; pwrite <= 0;
            if (phase == 4) calm = 1;
            // random: mostly inserts and queries around the grid area
            for (k = 0; k < 5; k++) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) send_item(OP_CLEAR, 16'($urandom), 16'($urandom),
                                        15'($urandom));
                else if (sel == 1) send_item(2'd3, 16'($urandom), 16'($urandom),
                                             15'($urandom));
                else if (sel < 4) send_item(2'($urandom_range(1, 2)), 16'($urandom),
                                            16'($urandom), 15'($urandom));
                else if (sel < 12) send_near(OP_INSERT, 1200, 1200, 600, 0);
                else send_near(OP_QUERY, 1200, 1200, 600, $urandom_range(0, 400));
            end
            drain();
        end

        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d input items and %0d results over five register settings",
                 item_count, result_count);
        $display("including off-grid, truncated, empty and clear cases");
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
